### src/assert_macros.svh
// Assertion macros shared by the deferred delivery timer queue RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDTQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### src/ddtq_pkg.sv
// Shared types and constants for the deferred delivery timer queue.
// No dependencies; imported by every other file of the block but assert_macros.svh.
`default_nettype none

package ddtq_pkg;

  localparam int TICK_W  = 32;
  localparam int DELAY_W = 20;
  localparam int TGT_W   = 8;
  localparam int PAY_W   = 32;
  localparam int NB_W    = 3;
  localparam int MAX_OUT = 32;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  localparam logic CMD_NOTIFY   = 1'b0;
  localparam logic CMD_SCHEDULE = 1'b1;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_FULL    = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [TGT_W-1:0]  target;
    logic [PAY_W-1:0]  payload;
    logic [NB_W-1:0]   nbytes;
  } slot_entry_t;

  typedef struct packed {
    logic clr;
    logic vld;
    logic busy;
  } cmp_ctl_t;

endpackage

`default_nettype wire

### src/ddtq_in_if.sv
// Input channel of the deferred delivery timer queue: valid/ready plus request fields.
// Depends on ddtq_pkg for the field widths.
`default_nettype none

interface ddtq_in_if import ddtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [TICK_W-1:0]  current_tick;
  logic [DELAY_W-1:0] delay_ticks;
  logic [TGT_W-1:0]   target_id;
  logic [PAY_W-1:0]   payload;
  logic [NB_W-1:0]    payload_bytes;

  modport source (output valid, cmd, current_tick, delay_ticks, target_id, payload,
                  payload_bytes, input ready);
  modport sink (input valid, cmd, current_tick, delay_ticks, target_id, payload,
                payload_bytes, output ready);
endinterface

`default_nettype wire

### src/ddtq_out_if.sv
// Result channel of the deferred delivery timer queue: valid/ready plus result fields.
// Depends on ddtq_pkg for the field widths.
`default_nettype none

interface ddtq_out_if import ddtq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [TGT_W-1:0] out_target;
  logic [PAY_W-1:0] out_payload;
  logic [NB_W-1:0]  out_bytes;
  logic             last;

  modport source (output valid, kind, out_target, out_payload, out_bytes, last,
                  input ready);
  modport sink (input valid, kind, out_target, out_payload, out_bytes, last,
                output ready);
endinterface

`default_nettype wire

### src/ddtq_slot_ram.sv
// Job slot memory: deadline, target, payload and byte count per slot.
// One write port, one registered read port. Depends on ddtq_pkg.
`default_nettype none

module ddtq_slot_ram import ddtq_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic        clk,
  input  wire logic        wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire slot_entry_t wr_data,
  input  wire logic        rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output slot_entry_t      rd_data
);

  slot_entry_t mem [DEPTH];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### src/ddtq_cmp_unit.sv
// Shared compare unit: keeps the earliest due job seen during one slot scan.
// Ties keep the earlier (lower) slot. Depends on ddtq_pkg.
`default_nettype none

module ddtq_cmp_unit import ddtq_pkg::*; #(
  parameter int AW = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmp_ctl_t          ctl,
  input  wire logic [AW-1:0]     idx,
  input  wire logic [TICK_W-1:0] now,
  input  wire slot_entry_t       entry,
  output logic                   best_vld,
  output logic [AW-1:0]          best_idx,
  output slot_entry_t            best
);

  logic        best_vld_r, best_vld_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  slot_entry_t best_r, best_nxt;
  logic        due;
  logic        better;

  always_comb begin
    due          = entry.deadline <= now;
    better       = !best_vld_r || (entry.deadline < best_r.deadline);
    best_vld_nxt = best_vld_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    if (ctl.clr) begin
      best_vld_nxt = 1'b0;
    end else if (ctl.vld && ctl.busy && due && better) begin
      best_vld_nxt = 1'b1;
      best_idx_nxt = idx;
      best_nxt     = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else begin
      best_vld_r <= best_vld_nxt;
    end
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
  end

  assign best_vld = best_vld_r;
  assign best_idx = best_idx_r;
  assign best     = best_r;

endmodule

`default_nettype wire

### src/deferred_delivery_timer_queue.sv
// Deferred delivery timer queue top level: sequencer, busy bits and result register.
// Uses ddtq_pkg, ddtq_in_if, ddtq_out_if, ddtq_slot_ram, ddtq_cmp_unit, assert_macros.svh.
//
// The block takes one transaction at a time and is not ready while it works on it.
// A schedule with zero delay, or any result, is staged in the pending register and then
// waits for the result register to drain. A schedule with a delay walks the busy bits one
// slot per cycle to find the lowest free slot. A notify runs one pass through the slot
// memory per delivered job plus a final pass that finds nothing more due; each pass
// reads one slot per cycle through the single memory read port. At most 32 jobs go
// out per notify; later due jobs stay stored. The next transaction is accepted while a
// result still waits in the output register.
`default_nettype none
`include "assert_macros.svh"

module deferred_delivery_timer_queue import ddtq_pkg::*; #(
  parameter int JOB_SLOTS = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ddtq_in_if.sink   in_ch,
  ddtq_out_if.source out_ch
);

  localparam int SLOT_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(JOB_SLOTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FREE = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_PASS = 5'b01000,
    ST_PUT  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [JOB_SLOTS-1:0] busy_r, busy_nxt;
  logic [SLOT_W-1:0]    scan_addr_r, scan_addr_nxt;
  logic                 issue_done_r, issue_done_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;

  logic [TICK_W-1:0]    now_r, now_nxt;
  logic [DELAY_W-1:0]   delay_r, delay_nxt;
  logic [TGT_W-1:0]     tgt_r, tgt_nxt;
  logic [PAY_W-1:0]     pay_r, pay_nxt;
  logic [NB_W-1:0]      nb_r, nb_nxt;

  logic                 pend_vld_r, pend_vld_nxt;
  logic                 pend_kind_r, pend_kind_nxt;
  logic [TGT_W-1:0]     pend_tgt_r, pend_tgt_nxt;
  logic [PAY_W-1:0]     pend_pay_r, pend_pay_nxt;
  logic [NB_W-1:0]      pend_nb_r, pend_nb_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [TGT_W-1:0]     out_tgt_r, out_tgt_nxt;
  logic [PAY_W-1:0]     out_pay_r, out_pay_nxt;
  logic [NB_W-1:0]      out_nb_r, out_nb_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_accept;
  logic                 out_free;
  logic                 take;
  logic [TICK_W:0]      dl_sum;
  logic                 wr_en;
  slot_entry_t          wr_data;
  logic                 rd_en;
  slot_entry_t          rd_data;
  cmp_ctl_t             cmp_ctl;
  logic                 best_vld;
  logic [SLOT_W-1:0]    best_idx;
  slot_entry_t          best;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign take        = best_vld && (n_r != CNT_W'(MAX_OUT));

  assign dl_sum = {1'b0, now_r} + (TICK_W + 1)'(delay_r);

  always_comb begin
    wr_data.deadline = dl_sum[TICK_W] ? {TICK_W{1'b1}} : dl_sum[TICK_W-1:0];
    wr_data.target   = tgt_r;
    wr_data.payload  = pay_r;
    wr_data.nbytes   = nb_r;
  end

  always_comb begin
    state_nxt      = state_r;
    busy_nxt       = busy_r;
    scan_addr_nxt  = scan_addr_r;
    issue_done_nxt = issue_done_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = scan_addr_r;
    n_nxt          = n_r;
    now_nxt        = now_r;
    delay_nxt      = delay_r;
    tgt_nxt        = tgt_r;
    pay_nxt        = pay_r;
    nb_nxt         = nb_r;
    pend_vld_nxt   = pend_vld_r;
    pend_kind_nxt  = pend_kind_r;
    pend_tgt_nxt   = pend_tgt_r;
    pend_pay_nxt   = pend_pay_r;
    pend_nb_nxt    = pend_nb_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_tgt_nxt    = out_tgt_r;
    out_pay_nxt    = out_pay_r;
    out_nb_nxt     = out_nb_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    cmp_ctl        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          now_nxt       = in_ch.current_tick;
          delay_nxt     = in_ch.delay_ticks;
          tgt_nxt       = in_ch.target_id;
          pay_nxt       = in_ch.payload;
          nb_nxt        = in_ch.payload_bytes;
          scan_addr_nxt = '0;
          if (in_ch.cmd == CMD_SCHEDULE) begin
            if (in_ch.delay_ticks == '0) begin
              pend_vld_nxt  = 1'b1;
              pend_kind_nxt = KIND_DELIVER;
              pend_tgt_nxt  = in_ch.target_id;
              pend_pay_nxt  = in_ch.payload;
              pend_nb_nxt   = in_ch.payload_bytes;
              state_nxt     = ST_PUT;
            end else begin
              state_nxt = ST_FREE;
            end
          end else begin
            issue_done_nxt = 1'b0;
            n_nxt          = '0;
            pend_vld_nxt   = 1'b0;
            cmp_ctl.clr    = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_FREE: begin
        if (!busy_r[scan_addr_r]) begin
          wr_en                 = 1'b1;
          busy_nxt[scan_addr_r] = 1'b1;
          state_nxt             = ST_IDLE;
        end else if (scan_addr_r == LAST_SLOT) begin
          pend_vld_nxt  = 1'b1;
          pend_kind_nxt = KIND_FULL;
          pend_tgt_nxt  = '0;
          pend_pay_nxt  = '0;
          pend_nb_nxt   = '0;
          state_nxt     = ST_PUT;
        end else begin
          scan_addr_nxt = scan_addr_r + SLOT_W'(1);
        end
      end
      ST_SCAN: begin
        if (!issue_done_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          if (scan_addr_r == LAST_SLOT) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_addr_nxt = scan_addr_r + SLOT_W'(1);
          end
        end
        cmp_ctl.vld  = rd_vld_r;
        cmp_ctl.busy = busy_r[rd_idx_r];
        if (rd_vld_r && (rd_idx_r == LAST_SLOT)) begin
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        if (take) begin
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_tgt_nxt   = pend_tgt_r;
              out_pay_nxt   = pend_pay_r;
              out_nb_nxt    = pend_nb_r;
              out_last_nxt  = 1'b0;
            end
            pend_vld_nxt       = 1'b1;
            pend_kind_nxt      = KIND_DELIVER;
            pend_tgt_nxt       = best.target;
            pend_pay_nxt       = best.payload;
            pend_nb_nxt        = best.nbytes;
            busy_nxt[best_idx] = 1'b0;
            n_nxt              = n_r + CNT_W'(1);
            cmp_ctl.clr        = 1'b1;
            scan_addr_nxt      = '0;
            issue_done_nxt     = 1'b0;
            state_nxt          = ST_SCAN;
          end
        end else if (pend_vld_r) begin
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_tgt_nxt   = pend_tgt_r;
          out_pay_nxt   = pend_pay_r;
          out_nb_nxt    = pend_nb_r;
          out_last_nxt  = 1'b1;
          pend_vld_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      busy_r       <= '0;
      issue_done_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      n_r          <= '0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= busy_nxt;
      issue_done_r <= issue_done_nxt;
      rd_vld_r     <= rd_vld_nxt;
      n_r          <= n_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    scan_addr_r <= scan_addr_nxt;
    rd_idx_r    <= rd_idx_nxt;
    now_r       <= now_nxt;
    delay_r     <= delay_nxt;
    tgt_r       <= tgt_nxt;
    pay_r       <= pay_nxt;
    nb_r        <= nb_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_tgt_r  <= pend_tgt_nxt;
    pend_pay_r  <= pend_pay_nxt;
    pend_nb_r   <= pend_nb_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tgt_r   <= out_tgt_nxt;
    out_pay_r   <= out_pay_nxt;
    out_nb_r    <= out_nb_nxt;
    out_last_r  <= out_last_nxt;
  end

  ddtq_slot_ram #(
    .DEPTH (JOB_SLOTS),
    .AW    (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (scan_addr_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_addr_r),
    .rd_data (rd_data)
  );

  ddtq_cmp_unit #(
    .AW (SLOT_W)
  ) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cmp_ctl),
    .idx      (rd_idx_r),
    .now      (now_r),
    .entry    (rd_data),
    .best_vld (best_vld),
    .best_idx (best_idx),
    .best     (best)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.out_target  = out_tgt_r;
  assign out_ch.out_payload = out_pay_r;
  assign out_ch.out_bytes   = out_nb_r;
  assign out_ch.last        = out_last_r;

  `DDTQ_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_accept, !in_ch.ready)
  `DDTQ_ASSERT_NOW(a_best_is_busy, clk, rst_n, (state_r == ST_PASS) && best_vld,
                   busy_r[best_idx])
  `DDTQ_ASSERT_NXT(a_taken_slot_freed, clk, rst_n,
                   (state_r == ST_PASS) && take && (!pend_vld_r || out_free),
                   !busy_r[$past(best_idx)])
  `DDTQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, n_r <= CNT_W'(MAX_OUT))

endmodule

`default_nettype wire

### bench/tb_deferred_delivery_timer_queue.sv
// Testbench for the deferred delivery timer queue: directed and random stimulus with a
// scoreboard that predicts every delivery and table-full result in order.
// Depends on ddtq_pkg, ddtq_in_if, ddtq_out_if and the deferred_delivery_timer_queue RTL.
`timescale 1ns / 1ps

package delivery_check_pkg;
  import ddtq_pkg::*;

  localparam int SLOT_COUNT = 32;

  typedef struct packed {
    logic               cmd;
    logic [TICK_W-1:0]  tick;
    logic [DELAY_W-1:0] delay;
    logic [TGT_W-1:0]   target;
    logic [PAY_W-1:0]   payload;
    logic [NB_W-1:0]    nbytes;
  } request_t;

  typedef struct packed {
    logic              kind;
    logic [TGT_W-1:0]  target;
    logic [PAY_W-1:0]  payload;
    logic [NB_W-1:0]   nbytes;
    logic              last;
  } result_t;

  class delivery_scoreboard;
    bit                slot_busy[SLOT_COUNT];
    logic [TICK_W-1:0] slot_deadline[SLOT_COUNT];
    logic [TGT_W-1:0]  slot_target[SLOT_COUNT];
    logic [PAY_W-1:0]  slot_payload[SLOT_COUNT];
    logic [NB_W-1:0]   slot_nbytes[SLOT_COUNT];
    result_t           expected_q[$];
    int failures;
    int schedules;
    int notifies;
    int deliveries_seen;
    int full_seen;

    function new();
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      failures = 0;
      schedules = 0;
      notifies = 0;
      deliveries_seen = 0;
      full_seen = 0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void note_request(request_t r);
      result_t          res;
      result_t          batch[$];
      logic [TICK_W:0]  sum;
      int               free_slot;
      int               best;
      bit               done;
      res = '0;
      if (r.cmd == CMD_SCHEDULE) begin
        schedules++;
        if (r.delay == '0) begin
          res.kind = KIND_DELIVER;
          res.target = r.target;
          res.payload = r.payload;
          res.nbytes = r.nbytes;
          res.last = 1'b1;
          expected_q.push_back(res);
        end else begin
          free_slot = -1;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!slot_busy[i] && free_slot < 0) free_slot = i;
          end
          if (free_slot < 0) begin
            res.kind = KIND_FULL;
            res.last = 1'b1;
            expected_q.push_back(res);
          end else begin
            sum = {1'b0, r.tick} + {{(TICK_W + 1 - DELAY_W){1'b0}}, r.delay};
            slot_busy[free_slot] = 1'b1;
            slot_deadline[free_slot] = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
            slot_target[free_slot] = r.target;
            slot_payload[free_slot] = r.payload;
            slot_nbytes[free_slot] = r.nbytes;
          end
        end
      end else begin
        notifies++;
        done = 1'b0;
        while (batch.size() < MAX_OUT && !done) begin
          best = -1;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_busy[i] && slot_deadline[i] <= r.tick &&
                (best < 0 || slot_deadline[i] < slot_deadline[best])) best = i;
          end
          if (best < 0) begin
            done = 1'b1;
          end else begin
            res.kind = KIND_DELIVER;
            res.target = slot_target[best];
            res.payload = slot_payload[best];
            res.nbytes = slot_nbytes[best];
            res.last = 1'b0;
            batch.push_back(res);
            slot_busy[best] = 1'b0;
          end
        end
        if (batch.size() > 0) begin
          res = batch.pop_back();
          res.last = 1'b1;
          batch.push_back(res);
        end
        foreach (batch[i]) expected_q.push_back(batch[i]);
      end
    endfunction

    function void report(string what, result_t want, result_t got);
      failures++;
      if (failures <= 10) begin
        $display("%s: expected kind=%0d target=%02h payload=%08h bytes=%0d last=%0d",
                 what, want.kind, want.target, want.payload, want.nbytes, want.last);
        $display("      actual   kind=%0d target=%02h payload=%08h bytes=%0d last=%0d",
                 got.kind, got.target, got.payload, got.nbytes, got.last);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (got.kind == KIND_FULL) full_seen++;
      else deliveries_seen++;
      if (expected_q.size() == 0) begin
        report("Unexpected result", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.kind !== want.kind || got.target !== want.target ||
            got.payload !== want.payload || got.nbytes !== want.nbytes ||
            got.last !== want.last) begin
          report("Result mismatch", want, got);
        end
      end
    endfunction
  endclass
endpackage

module tb_deferred_delivery_timer_queue;
  import ddtq_pkg::*;
  import delivery_check_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 3 * (SLOT_COUNT + 2);
  localparam int RANDOM_ITEMS = 200;

  logic clk;
  logic rst_n;
  ddtq_in_if  in_ch();
  ddtq_out_if out_ch();

  delivery_scoreboard sb;
  bit                 hold_request;
  int                 burst_left;
  logic [TICK_W-1:0]  tick_now;

  deferred_delivery_timer_queue #(.JOB_SLOTS(SLOT_COUNT)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic request_t make_request(logic cmd, logic [TICK_W-1:0] tick,
                                            logic [DELAY_W-1:0] delay,
                                            logic [TGT_W-1:0] target,
                                            logic [PAY_W-1:0] payload,
                                            logic [NB_W-1:0] nbytes);
    request_t r;
    r.cmd = cmd;
    r.tick = tick;
    r.delay = delay;
    r.target = target;
    r.payload = payload;
    r.nbytes = nbytes;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       delay_pick;
    pick = $urandom_range(0, 99);
    tick_now = tick_now + TICK_W'($urandom_range(0, 30));
    if (pick < 4) tick_now = $urandom;
    r = make_request(CMD_SCHEDULE, tick_now, DELAY_W'($urandom_range(1, 120)),
                     TGT_W'($urandom), $urandom, NB_W'($urandom_range(0, 7)));
    if (pick < 10) begin
      r.cmd = 1'($urandom);
      r.tick = $urandom;
      r.delay = DELAY_W'($urandom);
    end else if (pick < 62) begin
      delay_pick = $urandom_range(0, 19);
      if (delay_pick < 2) r.delay = '0;
      else if (delay_pick == 2) r.delay = DELAY_W'($urandom);
    end else begin
      r.cmd = CMD_NOTIFY;
      if ($urandom_range(0, 19) == 0) r.tick = '1;
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 15);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= r.cmd;
    in_ch.current_tick <= r.tick;
    in_ch.delay_ticks <= r.delay;
    in_ch.target_id <= r.target;
    in_ch.payload <= r.payload;
    in_ch.payload_bytes <= r.nbytes;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
  endtask

  initial begin : result_sink
    int      hold_left;
    int      mode;
    int      mode_left;
    result_t got;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.kind;
        got.target = out_ch.out_target;
        got.payload = out_ch.out_payload;
        got.nbytes = out_ch.out_bytes;
        got.last = out_ch.last;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    hold_request = 1'b0;
    burst_left = 0;
    tick_now = '0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NOTIFY;
    in_ch.current_tick = '0;
    in_ch.delay_ticks = '0;
    in_ch.target_id = '0;
    in_ch.payload = '0;
    in_ch.payload_bytes = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, immediate deliveries at the field extremes, then a saturated deadline.
    send_request(make_request(CMD_NOTIFY, '0, '0, '0, '0, '0));
    send_request(make_request(CMD_SCHEDULE, '1, '0, 8'hFF, 32'hFFFF_FFFF, 3'd7));
    send_request(make_request(CMD_SCHEDULE, '0, '0, 8'h00, 32'h0000_0000, 3'd0));
    send_request(make_request(CMD_SCHEDULE, '1, '1, 8'h5A, 32'h1234_5678, 3'd4));
    // Ordering by deadline, ties broken by slot, and reuse of the lowest free slot.
    send_request(make_request(CMD_SCHEDULE, 32'd100, 20'd1, 8'h11, 32'hA1A1_0001, 3'd1));
    send_request(make_request(CMD_SCHEDULE, 32'd100, 20'd5, 8'h22, 32'hB2B2_0002, 3'd2));
    send_request(make_request(CMD_SCHEDULE, 32'd102, 20'd3, 8'h33, 32'hC3C3_0003, 3'd3));
    send_request(make_request(CMD_SCHEDULE, 32'd90, 20'd10, 8'h44, 32'hD4D4_0004, 3'd5));
    send_request(make_request(CMD_NOTIFY, 32'd99, '0, '0, '0, '0));
    send_request(make_request(CMD_NOTIFY, 32'd101, '0, '0, '0, '0));
    send_request(make_request(CMD_SCHEDULE, 32'd101, 20'd4, 8'h55, 32'hE5E5_0005, 3'd6));
    send_request(make_request(CMD_NOTIFY, 32'd105, '0, '0, '0, '0));
    // Deadlines that just reach and that run past the top of the tick range.
    send_request(make_request(CMD_SCHEDULE, 32'hFFFF_FF00, 20'hFF, 8'h66, 32'h6666_6666,
                              3'd4));
    send_request(make_request(CMD_SCHEDULE, 32'hFFFF_FF00, 20'h100, 8'h77, 32'h7777_7777,
                              3'd3));
    send_request(make_request(CMD_NOTIFY, 32'hFFFF_FFFE, '0, '0, '0, '0));
    send_request(make_request(CMD_NOTIFY, '1, '0, '0, '0, '0));

    // Fill every slot, overflow the table while the receiver holds off, then flush all.
    tick_now = $urandom;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      send_request(make_request(CMD_SCHEDULE, tick_now, DELAY_W'($urandom_range(1, 1000)),
                                TGT_W'($urandom), $urandom, NB_W'($urandom_range(0, 7))));
    end
    hold_request = 1'b1;
    repeat (2) begin
      send_request(make_request(CMD_SCHEDULE, tick_now, DELAY_W'($urandom_range(1, 1000)),
                                TGT_W'($urandom), $urandom, NB_W'($urandom_range(0, 7))));
    end
    send_request(make_request(CMD_NOTIFY, '1, '0, '0, '0, '0));

    tick_now = TICK_W'($urandom_range(0, 5000));
    repeat (RANDOM_ITEMS) send_request(random_request());
    in_ch.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d schedule and %0d notify transactions, including a full table.",
             sb.schedules, sb.notifies);
    $display("Checked %0d deliveries and %0d table-full results; %0d failures.",
             sb.deliveries_seen, sb.full_seen, sb.failures);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
